// ----- hdl/ipsd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and offset tables for the inter-frame pixel stream decoder.
// No dependencies; imported by the controller and the datapath.
package ipsd_pkg;

	// Sizes of the fixed fields
	localparam int DIM_W  = 9;
	localparam int DIFF_W = 26;
	localparam int CFG_W  = 26;
	localparam int RUN_W  = 5;
	localparam int PIX_W  = 24;

	localparam logic [DIFF_W-1:0] DIFF_MAX = {DIFF_W{1'b1}};
	localparam logic [PIX_W-1:0]  WHITE    = 24'hFFFFFF;
	localparam logic [7:0]        BYTE_RAW = 8'hFF;

	// Reset values of the configuration registers
	localparam logic [DIM_W-1:0]  WIDTH_RST   = 9'd256;
	localparam logic [DIM_W-1:0]  HEIGHT_RST  = 9'd256;
	localparam logic [DIFF_W-1:0] KEY_TH_RST  = 26'd25067520;
	localparam logic [DIFF_W-1:0] REF_TH_RST  = 26'd5013504;

	// Register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_KEY_TH = 2'd2;
	localparam logic [1:0] REG_REF_TH = 2'd3;

	// Header codes (top three bits)
	localparam logic [2:0] CODE_RUN     = 3'd0;
	localparam logic [2:0] CODE_LUMA    = 3'd1;
	localparam logic [2:0] CODE_DELTA   = 3'd2;
	localparam logic [2:0] CODE_COPY    = 3'd3;

	// Error codes
	localparam logic [1:0] ERR_OK      = 2'd0;
	localparam logic [1:0] ERR_RANGE   = 2'd1;
	localparam logic [1:0] ERR_NOREF   = 2'd2;
	localparam logic [1:0] ERR_ZERORUN = 2'd3;

	// Pending payload kinds
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_RAW  = 2'd1;
	localparam logic [1:0] PEND_LUMA = 2'd2;

	// Pixel sources
	localparam logic [2:0] SRC_CALC = 3'd0;
	localparam logic [2:0] SRC_PREV = 3'd1;
	localparam logic [2:0] SRC_HERE = 3'd2;
	localparam logic [2:0] SRC_LAST = 3'd3;
	localparam logic [2:0] SRC_REF  = 3'd4;

	// What a decoded byte asks for
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_PIX  = 2'd1;
	localparam logic [1:0] KIND_RUN  = 2'd2;

	typedef logic signed [3:0] off_t;

	localparam off_t LAST_DR [64] = '{
		-4'sd5, -4'sd4, -4'sd4, -4'sd4,
		-4'sd3, -4'sd3, -4'sd3, -4'sd3, -4'sd3, -4'sd3, -4'sd3,
		-4'sd2, -4'sd2, -4'sd2, -4'sd2, -4'sd2, -4'sd2, -4'sd2,
		-4'sd1, -4'sd1, -4'sd1, -4'sd1, -4'sd1, -4'sd1, -4'sd1, -4'sd1, -4'sd1,
		4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0,
		4'sd1, 4'sd1, 4'sd1, 4'sd1, 4'sd1, 4'sd1, 4'sd1, 4'sd1, 4'sd1,
		4'sd2, 4'sd2, 4'sd2, 4'sd2, 4'sd2, 4'sd2, 4'sd2,
		4'sd3, 4'sd3, 4'sd3, 4'sd3, 4'sd3, 4'sd3, 4'sd3,
		4'sd4, 4'sd4, 4'sd4,
		4'sd5};

	localparam off_t LAST_DC [64] = '{
		4'sd0,
		-4'sd1, 4'sd0, 4'sd1,
		-4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3,
		-4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3,
		-4'sd4, -4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4,
		-4'sd5, -4'sd4, -4'sd3, -4'sd2, -4'sd1, 4'sd1, 4'sd2, 4'sd3, 4'sd4, 4'sd5,
		-4'sd4, -4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4,
		-4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3,
		-4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3,
		-4'sd1, 4'sd0, 4'sd1,
		4'sd0};

	localparam off_t REF_DR [32] = '{
		-4'sd3, -4'sd3,
		-4'sd2, -4'sd2, -4'sd2, -4'sd2, -4'sd2,
		-4'sd1, -4'sd1, -4'sd1, -4'sd1, -4'sd1, -4'sd1, -4'sd1,
		4'sd0, 4'sd0, 4'sd0, 4'sd0,
		4'sd1, 4'sd1, 4'sd1, 4'sd1, 4'sd1, 4'sd1, 4'sd1,
		4'sd2, 4'sd2, 4'sd2, 4'sd2, 4'sd2,
		4'sd3, 4'sd3};

	localparam off_t REF_DC [32] = '{
		-4'sd1, 4'sd1,
		-4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2,
		-4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3,
		-4'sd2, -4'sd1, 4'sd1, 4'sd2,
		-4'sd3, -4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2, 4'sd3,
		-4'sd2, -4'sd1, 4'sd0, 4'sd1, 4'sd2,
		-4'sd1, 4'sd1};

	// Controller to datapath
	typedef struct packed {
		logic load_byte;
		logic decode;
		logic rd_src;
		logic put_pix;
		logic commit;
		logic last_item;
		logic end_frame;
		logic sweep;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0]       kind;
		logic [RUN_W-1:0] run_len;
		logic             out_free;
		logic             done;
		logic             sweep_end;
	} stat_t;

	function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
		absdiff8 = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

// ----- hdl/ipsd_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the pixel stream decoder: sequences decode, memory reads, pixel
// commit, frame-end decision and store copy. Depends on ipsd_pkg.
module ipsd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ipsd_pkg::stat_t stat,
	output ipsd_pkg::cmd_t  cmd
);
	import ipsd_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DEC   = 3'd1;
	localparam logic [2:0] ST_RD    = 3'd2;
	localparam logic [2:0] ST_PIX   = 3'd3;
	localparam logic [2:0] ST_ACC   = 3'd4;
	localparam logic [2:0] ST_END   = 3'd5;
	localparam logic [2:0] ST_SWEEP = 3'd6;
	localparam logic [2:0] ST_DRAIN = 3'd7;

	logic [2:0]       state_q;
	logic [2:0]       state_nx;
	logic [RUN_W-1:0] run_left_q;
	logic             commit;

	assign in_ready = (state_q == ST_IDLE);
	assign commit   = (state_q == ST_ACC) && stat.out_free;

	// Commands are a decode of the state
	always_comb begin
		cmd           = '0;
		cmd.load_byte = in_valid && in_ready;
		cmd.decode    = (state_q == ST_DEC);
		cmd.rd_src    = (state_q == ST_RD);
		cmd.put_pix   = (state_q == ST_PIX);
		cmd.commit    = commit;
		cmd.last_item = (run_left_q == RUN_W'(1)) || stat.done;
		cmd.end_frame = (state_q == ST_END);
		cmd.sweep     = (state_q == ST_SWEEP);
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nx = ST_DEC;
			end
			ST_DEC: begin
				if (stat.kind == KIND_NONE) state_nx = ST_IDLE;
				else state_nx = ST_RD;
			end
			ST_RD:  state_nx = ST_PIX;
			ST_PIX: state_nx = ST_ACC;
			ST_ACC: begin
				if (commit) begin
					if (stat.done) state_nx = ST_END;
					else if (run_left_q > RUN_W'(1)) state_nx = ST_RD;
					else state_nx = ST_IDLE;
				end
			end
			ST_END: state_nx = ST_SWEEP;
			ST_SWEEP: begin
				if (stat.sweep_end) state_nx = ST_DRAIN;
			end
			ST_DRAIN: state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// State and run counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			run_left_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_DEC) begin
				run_left_q <= (stat.kind == KIND_RUN) ? stat.run_len : RUN_W'(1);
			end else if (commit) begin
				run_left_q <= run_left_q - RUN_W'(1);
			end
		end
	end

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC) |-> (run_left_q != '0))
		else $error("pixel committed with no run left");

	a_end_to_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_END) |=> (state_q == ST_SWEEP))
		else $error("frame end not followed by store copy");

	a_sweep_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && stat.sweep_end) |=> (state_q == ST_DRAIN))
		else $error("store copy did not finish at last address");

endmodule

// ----- hdl/ipsd_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the pixel stream decoder: configuration, decode, frame stores,
// position, difference sum and output register. Depends on ipsd_pkg.
module ipsd_datapath #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [ipsd_pkg::CFG_W-1:0]  cfg_data,
	input  logic [7:0]                  code_byte,
	input  ipsd_pkg::cmd_t              cmd,
	output ipsd_pkg::stat_t             stat,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  red,
	output logic [7:0]                  green,
	output logic [7:0]                  blue,
	output logic                        last_of_item,
	output logic                        frame_done,
	output logic [1:0]                  error_code
);
	import ipsd_pkg::*;

	localparam int FW  = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW  = $clog2(FW);
	localparam int RAW = $clog2(2 * FW);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int EWW = $clog2(MAX_WIDTH + 1);
	localparam int EHW = $clog2(MAX_HEIGHT + 1);
	localparam int CSW = CW + 2;
	localparam int RSW = RW + 2;
	localparam logic signed [AW+1:0] MAXW_S = (AW+2)'(MAX_WIDTH);

	// Configuration
	logic [DIM_W-1:0]  width_q, height_q;
	logic [DIFF_W-1:0] key_th_q, ref_th_q;
	logic [EWW-1:0]    eff_w;
	logic [EHW-1:0]    eff_h;

	// Frame state
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [AW-1:0]     pos_addr_q, row_base_q;
	logic [PIX_W-1:0]  prev_q;
	logic [DIFF_W-1:0] diff_q;
	logic [1:0]        ref_valid_q;
	logic              first_q;
	logic [1:0]        pend_kind_q;
	logic [1:0]        pend_cnt_q;
	logic [7:0]        pend_b0_q, pend_b1_q, luma_hdr_q;

	// Per-item registers
	logic [7:0]        byte_q;
	logic [1:0]        err_q;
	logic [2:0]        src_sel_q;
	logic [PIX_W-1:0]  calc_q;
	logic [AW-1:0]     src_addr_q;
	logic [RAW-1:0]    ref_addr_q;
	logic [PIX_W-1:0]  pix_q;

	// Store copy
	logic [AW-1:0]     sweep_addr_q;
	logic [AW-1:0]     sweep_addr_s1;
	logic              sweep_v_s1;
	logic              copy_ref_q;
	logic              copy_bank_q;

	// Memories and their read registers
	logic [PIX_W-1:0]  cur_mem  [FW];
	logic [PIX_W-1:0]  last_mem [FW];
	logic [PIX_W-1:0]  ref_mem  [2*FW];
	logic [PIX_W-1:0]  cur_rd_q, last_rd_q, ref_rd_q;

	// Output register
	logic              out_valid_q;
	logic              out_free;

	// Decode results
	logic [2:0]        typ;
	logic              is_ref;
	logic              ref_f;
	off_t              dr, dc;
	logic signed [RSW-1:0] r_s;
	logic signed [CSW-1:0] c_s;
	logic              oob;
	logic signed [AW+1:0]  off_a;
	logic [1:0]        dec_kind;
	logic [RUN_W-1:0]  dec_len;
	logic [1:0]        dec_err;
	logic [2:0]        dec_src;
	logic [PIX_W-1:0]  dec_calc;
	logic [7:0]        dg8, dgr8, dgb8;
	logic [7:0]        ldg8, ldgr8, ldgb8;
	logic [PIX_W-1:0]  small_pix, luma_pix;

	logic [PIX_W-1:0]  pix_nx;
	logic              col_end, row_end;
	logic [9:0]        pix_diff;
	logic [DIFF_W:0]   diff_sum;
	logic              sel0, sel1;

	// Clamp the frame size to 1..max
	always_comb begin
		if (width_q == '0) eff_w = EWW'(1);
		else if (int'(width_q) > MAX_WIDTH) eff_w = EWW'(MAX_WIDTH);
		else eff_w = EWW'(width_q);
		if (height_q == '0) eff_h = EHW'(1);
		else if (int'(height_q) > MAX_HEIGHT) eff_h = EHW'(MAX_HEIGHT);
		else eff_h = EHW'(height_q);
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			key_th_q <= KEY_TH_RST;
			ref_th_q <= REF_TH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				REG_KEY_TH: key_th_q <= cfg_data[DIFF_W-1:0];
				REG_REF_TH: ref_th_q <= cfg_data[DIFF_W-1:0];
				default: ;
			endcase
		end
	end

	// Offset lookup and bounds check
	assign typ    = byte_q[7:5];
	assign is_ref = typ[2] & typ[1];
	assign ref_f  = byte_q[4];
	always_comb begin
		if (is_ref) begin
			dr = REF_DR[{byte_q[5], byte_q[3:0]}];
			dc = REF_DC[{byte_q[5], byte_q[3:0]}];
		end else begin
			dr = LAST_DR[byte_q[5:0]];
			dc = LAST_DC[byte_q[5:0]];
		end
	end
	assign r_s = $signed({2'b00, row_q}) + RSW'(dr);
	assign c_s = $signed({2'b00, col_q}) + CSW'(dc);
	assign oob = (r_s < 0) || (c_s < 0)
		|| (r_s >= $signed(RSW'(eff_h))) || (c_s >= $signed(CSW'(eff_w)));
	assign off_a = $signed({2'b00, pos_addr_q}) + (AW+2)'(dr) * MAXW_S + (AW+2)'(dc);

	// Small delta and luma delta against the previous pixel
	assign dg8   = 8'(byte_q[4:3]) - 8'd1;
	assign dgr8  = 8'(byte_q[2:1]) - 8'd1;
	assign dgb8  = 8'(byte_q[0]);
	assign small_pix = {prev_q[23:16] - (dg8 - dgr8), prev_q[15:8] - dg8,
		prev_q[7:0] - (dg8 - dgb8)};
	assign ldg8  = 8'(luma_hdr_q[4:0]) - 8'd15;
	assign ldgr8 = 8'(byte_q[7:4]) - 8'd7;
	assign ldgb8 = 8'(byte_q[3:0]) - 8'd7;
	assign luma_pix = {prev_q[23:16] - (ldg8 - ldgr8), prev_q[15:8] - ldg8,
		prev_q[7:0] - (ldg8 - ldgb8)};

	// Classify the held byte
	always_comb begin
		dec_kind = KIND_NONE;
		dec_len  = RUN_W'(1);
		dec_err  = ERR_OK;
		dec_src  = SRC_PREV;
		dec_calc = prev_q;
		if (pend_kind_q == PEND_RAW) begin
			if (pend_cnt_q == 2'd2) begin
				dec_kind = KIND_PIX;
				dec_src  = SRC_CALC;
				dec_calc = {pend_b0_q, pend_b1_q, byte_q};
			end
		end else if (pend_kind_q == PEND_LUMA) begin
			dec_kind = KIND_PIX;
			dec_src  = SRC_CALC;
			dec_calc = luma_pix;
		end else if (typ == CODE_RUN || typ == CODE_COPY) begin
			dec_kind = KIND_RUN;
			dec_src  = (typ == CODE_COPY) ? SRC_HERE : SRC_PREV;
			if (byte_q[4:0] == '0) begin
				dec_err = ERR_ZERORUN;
			end else begin
				dec_len = byte_q[4:0];
			end
		end else if (byte_q == BYTE_RAW || typ == CODE_LUMA) begin
			dec_kind = KIND_NONE;
		end else if (typ == CODE_DELTA) begin
			dec_kind = KIND_PIX;
			dec_src  = SRC_CALC;
			dec_calc = small_pix;
		end else begin
			dec_kind = KIND_PIX;
			if (is_ref && !ref_valid_q[ref_f]) dec_err = ERR_NOREF;
			else if (oob) dec_err = ERR_RANGE;
			else dec_src = is_ref ? SRC_REF : SRC_LAST;
		end
	end

	// Pixel from its source
	always_comb begin
		case (src_sel_q)
			SRC_CALC: pix_nx = calc_q;
			SRC_PREV: pix_nx = prev_q;
			SRC_HERE: pix_nx = last_rd_q;
			SRC_LAST: pix_nx = last_rd_q;
			SRC_REF:  pix_nx = ref_rd_q;
			default:  pix_nx = prev_q;
		endcase
	end

	// Difference against the last frame and position wrap
	assign pix_diff = 10'(absdiff8(pix_q[23:16], last_rd_q[23:16]))
		+ 10'(absdiff8(pix_q[15:8], last_rd_q[15:8]))
		+ 10'(absdiff8(pix_q[7:0], last_rd_q[7:0]));
	assign diff_sum = {1'b0, diff_q} + (DIFF_W+1)'(pix_diff);
	assign col_end  = (EWW'(col_q) + EWW'(1)) >= eff_w;
	assign row_end  = (EHW'(row_q) + EHW'(1)) >= eff_h;
	assign sel0 = !ref_valid_q[0] || (diff_q >= key_th_q);
	assign sel1 = !sel0 && (!ref_valid_q[1] || (diff_q >= ref_th_q));

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		stat           = '0;
		stat.kind      = dec_kind;
		stat.run_len   = dec_len;
		stat.out_free  = out_free;
		stat.done      = col_end && row_end;
		stat.sweep_end = (sweep_addr_q == AW'(FW - 1));
	end

	// Per-item payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_byte) byte_q <= code_byte;
		if (cmd.decode) begin
			err_q      <= dec_err;
			src_sel_q  <= dec_src;
			calc_q     <= dec_calc;
			src_addr_q <= off_a[AW-1:0];
			ref_addr_q <= ref_f ? (RAW'(off_a[AW-1:0]) + RAW'(FW)) : RAW'(off_a[AW-1:0]);
		end
		if (cmd.put_pix) pix_q <= pix_nx;
		if (cmd.decode && pend_kind_q == PEND_RAW) begin
			if (pend_cnt_q == 2'd0) pend_b0_q <= byte_q;
			if (pend_cnt_q == 2'd1) pend_b1_q <= byte_q;
		end
		if (cmd.decode && pend_kind_q == PEND_NONE && typ == CODE_LUMA) begin
			luma_hdr_q <= byte_q;
		end
		if (cmd.commit) begin
			red          <= pix_q[23:16];
			green        <= pix_q[15:8];
			blue         <= pix_q[7:0];
			last_of_item <= cmd.last_item;
			frame_done   <= col_end && row_end;
			error_code   <= err_q;
		end
	end

	// Frame stores
	always_ff @(posedge clk) begin
		if (cmd.put_pix) cur_mem[pos_addr_q] <= pix_nx;
		if (cmd.sweep) cur_rd_q <= cur_mem[sweep_addr_q];
	end

	always_ff @(posedge clk) begin
		if (sweep_v_s1) last_mem[sweep_addr_s1] <= cur_rd_q;
		if (cmd.rd_src) begin
			last_rd_q <= last_mem[(src_sel_q == SRC_HERE) ? pos_addr_q : src_addr_q];
		end else if (cmd.put_pix) begin
			last_rd_q <= last_mem[pos_addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_v_s1 && copy_ref_q) begin
			ref_mem[copy_bank_q ? (RAW'(sweep_addr_s1) + RAW'(FW)) : RAW'(sweep_addr_s1)]
				<= cur_rd_q;
		end
		if (cmd.rd_src) ref_rd_q <= ref_mem[ref_addr_q];
	end

	always_ff @(posedge clk) begin
		sweep_addr_s1 <= sweep_addr_q;
	end

	// Control state: position, previous pixel, pending payload, difference, references
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			pos_addr_q   <= '0;
			row_base_q   <= '0;
			prev_q       <= WHITE;
			diff_q       <= '0;
			ref_valid_q  <= '0;
			first_q      <= 1'b1;
			pend_kind_q  <= PEND_NONE;
			pend_cnt_q   <= '0;
			sweep_addr_q <= '0;
			sweep_v_s1   <= 1'b0;
			copy_ref_q   <= 1'b0;
			copy_bank_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			sweep_v_s1 <= cmd.sweep;

			// Track pending payload bytes
			if (cmd.decode) begin
				if (pend_kind_q == PEND_RAW) begin
					if (pend_cnt_q == 2'd2) begin
						pend_kind_q <= PEND_NONE;
						pend_cnt_q  <= '0;
					end else begin
						pend_cnt_q <= pend_cnt_q + 2'd1;
					end
				end else if (pend_kind_q == PEND_LUMA) begin
					pend_kind_q <= PEND_NONE;
				end else if (byte_q == BYTE_RAW) begin
					pend_kind_q <= PEND_RAW;
					pend_cnt_q  <= '0;
				end else if (typ == CODE_LUMA) begin
					pend_kind_q <= PEND_LUMA;
				end
			end

			if (cmd.put_pix) prev_q <= pix_nx;

			// Commit a pixel: accumulate difference, advance position
			if (cmd.commit) begin
				if (!first_q) diff_q <= (diff_sum > {1'b0, DIFF_MAX}) ? DIFF_MAX
					: diff_sum[DIFF_W-1:0];
				if (col_end) begin
					col_q      <= '0;
					row_q      <= row_q + RW'(1);
					row_base_q <= row_base_q + AW'(MAX_WIDTH);
					pos_addr_q <= row_base_q + AW'(MAX_WIDTH);
				end else begin
					col_q      <= col_q + CW'(1);
					pos_addr_q <= pos_addr_q + AW'(1);
				end
			end

			// Pick the reference to replace and start a new frame
			if (cmd.end_frame) begin
				copy_ref_q  <= sel0 || sel1;
				copy_bank_q <= sel1;
				if (sel0) ref_valid_q[0] <= 1'b1;
				if (sel1) ref_valid_q[1] <= 1'b1;
				first_q      <= 1'b0;
				prev_q       <= WHITE;
				col_q        <= '0;
				row_q        <= '0;
				pos_addr_q   <= '0;
				row_base_q   <= '0;
				pend_kind_q  <= PEND_NONE;
				pend_cnt_q   <= '0;
				diff_q       <= '0;
				sweep_addr_q <= '0;
			end

			if (cmd.sweep) sweep_addr_q <= sweep_addr_q + AW'(1);

			// Output handshake
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hdl/inter_frame_pixel_stream_decoder.sv -----
`timescale 1ns / 1ps
// Inter-frame pixel stream decoder: one code byte per request in, RGB pixels out.
// A byte passes through decode, source read, pixel forming and commit to the output
// register; a byte without a pixel returns to idle after decode. A run repeats read,
// form and commit for each pixel, and a commit waits while the output is held. A frame
// end starts a store copy, during which no byte is accepted. Reset (arst_n low, async)
// restores default sizes and thresholds, white previous pixel and no valid reference.
module inter_frame_pixel_stream_decoder #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [ipsd_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  code_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  red,
	output logic [7:0]                  green,
	output logic [7:0]                  blue,
	output logic                        last_of_item,
	output logic                        frame_done,
	output logic [1:0]                  error_code
);
	import ipsd_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	ipsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ipsd_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.code_byte    (code_byte),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.last_of_item (last_of_item),
		.frame_done   (frame_done),
		.error_code   (error_code)
	);

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for inter_frame_pixel_stream_decoder: directed code-byte table, then random
// code streams, checked pixel by pixel against a behavioral frame decoder.
// Depends on hdl/ipsd_pkg.sv and hdl/inter_frame_pixel_stream_decoder.sv.
module testbench;
	import ipsd_pkg::*;

	localparam int MAXW    = 256;
	localparam int FRAME_N = 65536;
	localparam int LIMIT   = 4000000;
	localparam int COPY_WAIT = 65600;
	localparam logic [25:0] TH_MAX = 26'd50135040;

	typedef enum logic [2:0] {
		OP_RUN, OP_LUMA, OP_DELTA, OP_COPY, OP_LAST_LO, OP_LAST_HI, OP_REF_LO, OP_REF_HI
	} op_e;

	typedef struct {
		logic [23:0] pix;
		bit          last;
		bit          done;
		logic [1:0]  err;
	} pixel_exp_t;

	typedef struct {
		bit           is_cfg;
		logic [1:0]   idx;
		logic [25:0]  val;
		logic [7:0]   b;
		bit           typed;
		logic [23:0]  pix;
		logic [1:0]   err;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] code_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] red, green, blue;
	logic last_of_item, frame_done;
	logic [1:0] error_code;

	inter_frame_pixel_stream_decoder DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .code_byte(code_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.red(red), .green(green), .blue(blue),
		.last_of_item(last_of_item), .frame_done(frame_done), .error_code(error_code)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Decoder state mirror
	logic [23:0] cur_px [FRAME_N];
	logic [23:0] last_px [FRAME_N];
	logic [23:0] ref_px [2][FRAME_N];
	bit cur_wr [FRAME_N];
	bit last_wr [FRAME_N];
	bit ref_wr [2][FRAME_N];
	bit ref_ok [2];
	bit first_fr;
	logic [8:0] w_reg, h_reg;
	logic [25:0] key_th, ref_th, diff_sum;
	logic [23:0] prev_px;
	int row, col;
	logic [1:0] pend_kind;
	int pend_cnt;
	logic [7:0] raw_b [3];
	logic [7:0] luma_hdr;
	int last_dr [64], last_dc [64], ref_dr [32], ref_dc [32];

	pixel_exp_t pixel_q [$];
	int err_cnt = 0, cyc = 0, items = 0, pixels = 0, frames = 0;
	bit copy_busy = 0;
	int burst_left = 0;
	int stall_mode = 0;

	step_t dir_tab [27] = '{
		'{0, REG_WIDTH, 0, 8'h00, 1, WHITE, ERR_ZERORUN},
		'{0, REG_WIDTH, 0, 8'h1F, 1, WHITE, ERR_OK},
		'{0, REG_WIDTH, 0, 8'hFF, 0, 0, ERR_OK},
		'{0, REG_WIDTH, 0, 8'h00, 0, 0, ERR_OK},
		'{0, REG_WIDTH, 0, 8'h00, 0, 0, ERR_OK},
		'{0, REG_WIDTH, 0, 8'h00, 1, 24'h000000, ERR_OK},
		'{0, REG_WIDTH, 0, 8'hFF, 0, 0, ERR_OK},
		'{0, REG_WIDTH, 0, 8'hFF, 0, 0, ERR_OK},
		'{0, REG_WIDTH, 0, 8'hFF, 0, 0, ERR_OK},
		'{0, REG_WIDTH, 0, 8'hFF, 1, WHITE, ERR_OK},
		'{0, REG_WIDTH, 0, 8'hC0, 1, WHITE, ERR_NOREF},
		'{0, REG_WIDTH, 0, 8'hF0, 1, WHITE, ERR_NOREF},
		'{0, REG_WIDTH, 0, 8'h80, 1, WHITE, ERR_RANGE},
		'{0, REG_WIDTH, 0, 8'h20, 0, 0, ERR_OK},
		'{0, REG_WIDTH, 0, 8'h00, 1, 24'h070E07, ERR_OK},
		'{0, REG_WIDTH, 0, 8'h3F, 0, 0, ERR_OK},
		'{0, REG_WIDTH, 0, 8'hFF, 0, 0, ERR_OK},
		'{0, REG_WIDTH, 0, 8'h40, 0, 0, ERR_OK},
		'{0, REG_WIDTH, 0, 8'h5F, 0, 0, ERR_OK},
		'{1, REG_WIDTH, 0, 8'h00, 0, 0, ERR_OK},
		'{1, REG_HEIGHT, 0, 8'h00, 0, 0, ERR_OK},
		'{0, REG_WIDTH, 0, 8'h05, 0, 0, ERR_OK},
		'{1, REG_WIDTH, 511, 8'h00, 0, 0, ERR_OK},
		'{1, REG_HEIGHT, 1, 8'h00, 0, 0, ERR_OK},
		'{0, REG_WIDTH, 0, 8'h60, 0, 0, ERR_OK},
		'{0, REG_WIDTH, 0, 8'hC1, 0, 0, ERR_OK},
		'{0, REG_WIDTH, 0, 8'hD0, 0, 0, ERR_OK}
	};

	function automatic int eff_w();
		if (w_reg == 0) return 1;
		return (w_reg > MAXW) ? MAXW : int'(w_reg);
	endfunction

	function automatic int eff_h();
		if (h_reg == 0) return 1;
		return (h_reg > MAXW) ? MAXW : int'(h_reg);
	endfunction

	function automatic int chan_diff(logic [7:0] a, logic [7:0] b);
		return (a > b) ? int'(a - b) : int'(b - a);
	endfunction

	// Target of an offset copy code, relative to the current position
	function automatic void copy_target(input logic [7:0] b, output int r, output int c,
			output bit is_ref, output int f);
		int ind;
		op_e op;
		op = op_e'(b[7:5]);
		is_ref = (op == OP_REF_LO || op == OP_REF_HI);
		f = b[4];
		if (is_ref) begin
			ind = b[3:0] + ((op == OP_REF_HI) ? 16 : 0);
			r = row + ref_dr[ind];
			c = col + ref_dc[ind];
		end else begin
			ind = b[4:0] + ((op == OP_LAST_HI) ? 32 : 0);
			r = row + last_dr[ind];
			c = col + last_dc[ind];
		end
	endfunction

	// Turn header codes that would read a frame store entry never written into run codes
	function automatic logic [7:0] safe_header(logic [7:0] b);
		int r, c, f, cnt;
		bit is_ref, in_frame;
		op_e op;
		op = op_e'(b[7:5]);
		if (pend_kind != PEND_NONE || b == BYTE_RAW) return b;
		if (op == OP_COPY) begin
			cnt = (b[4:0] == 0) ? 1 : b[4:0];
			r = row;
			c = col;
			for (int k = 0; k < cnt; k++) begin
				if (!last_wr[r * MAXW + c]) return {OP_RUN, b[4:0]};
				c++;
				if (c >= eff_w()) begin
					c = 0;
					r++;
					if (r >= eff_h()) return b;
				end
			end
		end else if (op >= OP_LAST_LO) begin
			copy_target(b, r, c, is_ref, f);
			in_frame = r >= 0 && c >= 0 && r < eff_h() && c < eff_w();
			if (in_frame && !is_ref && !last_wr[r * MAXW + c]) return {OP_RUN, b[4:0]};
			if (in_frame && is_ref && ref_ok[f] && !ref_wr[f][r * MAXW + c])
				return {OP_RUN, b[4:0]};
		end
		return b;
	endfunction

	// Close a frame: update the reference and last stores, restart decoding
	task automatic close_frame();
		int f;
		f = -1;
		if (!ref_ok[0] || diff_sum >= key_th) f = 0;
		else if (!ref_ok[1] || diff_sum >= ref_th) f = 1;
		for (int i = 0; i < FRAME_N; i++) begin
			if (f >= 0) begin
				ref_px[f][i] = cur_px[i];
				ref_wr[f][i] = cur_wr[i];
			end
			last_px[i] = cur_px[i];
			last_wr[i] = cur_wr[i];
		end
		if (f >= 0) ref_ok[f] = 1;
		first_fr = 0;
		prev_px = WHITE;
		row = 0;
		col = 0;
		pend_kind = PEND_NONE;
		pend_cnt = 0;
		diff_sum = '0;
		copy_busy = 1;
		frames++;
	endtask

	// Store one pixel, advance the position and queue the expected output
	task automatic emit_pixel(input logic [23:0] p, input logic [1:0] e, output bit done);
		int a, d;
		logic [23:0] l;
		a = row * MAXW + col;
		done = 0;
		cur_px[a] = p;
		cur_wr[a] = 1;
		if (!first_fr) begin
			l = last_px[a];
			d = chan_diff(p[23:16], l[23:16]) + chan_diff(p[15:8], l[15:8])
				+ chan_diff(p[7:0], l[7:0]);
			diff_sum = (diff_sum > DIFF_MAX - d) ? DIFF_MAX : diff_sum + d;
		end
		col++;
		if (col >= eff_w()) begin
			col = 0;
			row++;
			if (row >= eff_h()) done = 1;
		end
		pixel_q.push_back('{p, 0, done, e});
		if (done) close_frame();
	endtask

	function automatic logic [23:0] delta_from_prev(int dr, int dg, int db);
		logic [7:0] r, g, b;
		r = prev_px[23:16] - 8'(dr);
		g = prev_px[15:8] - 8'(dg);
		b = prev_px[7:0] - 8'(db);
		return {r, g, b};
	endfunction

	// Decode one accepted code byte into expected pixels
	task automatic decode_byte(input logic [7:0] b);
		int n0, cnt, dg, dgr, dgb, r, c, f;
		bit done, is_ref;
		logic [1:0] e;
		logic [23:0] p;
		op_e op;
		n0 = pixel_q.size();
		op = op_e'(b[7:5]);
		if (pend_kind == PEND_RAW) begin
			raw_b[pend_cnt] = b;
			pend_cnt++;
			if (pend_cnt == 3) begin
				pend_kind = PEND_NONE;
				pend_cnt = 0;
				prev_px = {raw_b[0], raw_b[1], raw_b[2]};
				emit_pixel(prev_px, ERR_OK, done);
			end
		end else if (pend_kind == PEND_LUMA) begin
			dg = int'(luma_hdr[4:0]) - 15;
			dgr = int'(b[7:4]) - 7;
			dgb = int'(b[3:0]) - 7;
			pend_kind = PEND_NONE;
			prev_px = delta_from_prev(dg - dgr, dg, dg - dgb);
			emit_pixel(prev_px, ERR_OK, done);
		end else if (op == OP_RUN || op == OP_COPY) begin
			cnt = b[4:0];
			e = ERR_OK;
			if (cnt == 0) begin
				cnt = 1;
				e = ERR_ZERORUN;
			end
			for (int k = 0; k < cnt; k++) begin
				if (op == OP_COPY) prev_px = last_px[row * MAXW + col];
				emit_pixel(prev_px, e, done);
				if (done) break;
			end
		end else if (b == BYTE_RAW) begin
			pend_kind = PEND_RAW;
			pend_cnt = 0;
		end else if (op == OP_LUMA) begin
			pend_kind = PEND_LUMA;
			luma_hdr = b;
		end else if (op == OP_DELTA) begin
			dg = int'(b[4:3]) - 1;
			dgr = int'(b[2:1]) - 1;
			dgb = b[0];
			prev_px = delta_from_prev(dg - dgr, dg, dg - dgb);
			emit_pixel(prev_px, ERR_OK, done);
		end else begin
			copy_target(b, r, c, is_ref, f);
			p = prev_px;
			e = ERR_OK;
			if (is_ref && !ref_ok[f]) e = ERR_NOREF;
			else if (r < 0 || c < 0 || r >= eff_h() || c >= eff_w()) e = ERR_RANGE;
			else p = is_ref ? ref_px[f][r * MAXW + c] : last_px[r * MAXW + c];
			prev_px = p;
			emit_pixel(p, e, done);
		end
		if (pixel_q.size() > n0) pixel_q[pixel_q.size() - 1].last = 1;
	endtask

	task automatic report_bad(input string what, input logic [31:0] got, input logic [31:0] exp);
		err_cnt++;
		if (err_cnt <= 30)
			$display("mismatch %s: got %0h expected %0h, cycle %0d", what, got, exp, cyc);
	endtask

	// Send one code byte: gaps between bursts, hold until the request is taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		cfg_we <= 1'b0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		code_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items++;
		decode_byte(b);
	endtask

	// Let the block drain, including a store copy after a frame end
	task automatic wait_idle();
		in_valid <= 1'b0;
		cfg_we <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (copy_busy ? COPY_WAIT : 8) @(posedge clk);
		copy_busy = 0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [25:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_WIDTH:  w_reg = val[8:0];
			REG_HEIGHT: h_reg = val[8:0];
			REG_KEY_TH: key_th = val;
			default:    ref_th = val;
		endcase
	endtask

	function automatic logic [25:0] pick_threshold();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return TH_MAX;
			default: return $urandom_range(0, 4000);
		endcase
	endfunction

	function automatic logic [4:0] pick_count();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) return 5'd0;
		if (k == 1) return $urandom_range(5, 31);
		return $urandom_range(1, 4);
	endfunction

	// Receiver stalls and output checking
	always @(posedge clk) begin
		pixel_exp_t x;
		cyc <= cyc + 1;
		if (cyc % 97 == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (cyc % 5 != 0);
		endcase
		if (arst_n && out_valid && out_ready) begin
			pixels++;
			if (pixel_q.size() == 0) begin
				report_bad("unexpected pixel", {red, green, blue}, 0);
			end else begin
				x = pixel_q.pop_front();
				if (red !== x.pix[23:16]) report_bad("red", red, x.pix[23:16]);
				if (green !== x.pix[15:8]) report_bad("green", green, x.pix[15:8]);
				if (blue !== x.pix[7:0]) report_bad("blue", blue, x.pix[7:0]);
				if (last_of_item !== x.last) report_bad("last_of_item", last_of_item, x.last);
				if (frame_done !== x.done) report_bad("frame_done", frame_done, x.done);
				if (error_code !== x.err) report_bad("error_code", error_code, x.err);
			end
		end
		if (cyc > LIMIT) begin
			$display("timeout after %0d cycles", cyc);
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		int k, s, kind;
		logic [7:0] b;
		logic [8:0] w_tab [8] = '{9'd511, 9'd16, 9'd1, 9'd32, 9'd12, 9'd7, 9'd20, 9'd256};
		logic [8:0] h_tab [8] = '{9'd1, 9'd8, 9'd511, 9'd4, 9'd10, 9'd3, 9'd6, 9'd256};

		// Build the offset tables: rows of symmetric column spans
		k = 0;
		for (int dr = -5; dr <= 5; dr++) begin
			s = (dr == 5 || dr == -5) ? 0 : (dr == 4 || dr == -4) ? 1
				: (dr == 0) ? 5 : (dr == 1 || dr == -1) ? 4 : 3;
			for (int dc = -s; dc <= s; dc++) begin
				if (dr != 0 || dc != 0) begin
					last_dr[k] = dr;
					last_dc[k] = dc;
					k++;
				end
			end
		end
		k = 0;
		for (int dr = -3; dr <= 3; dr++) begin
			s = (dr == 3 || dr == -3) ? 1 : (dr == 1 || dr == -1) ? 3 : 2;
			for (int dc = -s; dc <= s; dc++) begin
				if (dc != 0 || (dr != 0 && dr != 3 && dr != -3)) begin
					ref_dr[k] = dr;
					ref_dc[k] = dc;
					k++;
				end
			end
		end

		// Reset state of the mirror
		for (int i = 0; i < FRAME_N; i++) begin
			cur_wr[i] = 0;
			last_wr[i] = 0;
			ref_wr[0][i] = 0;
			ref_wr[1][i] = 0;
		end
		ref_ok[0] = 0;
		ref_ok[1] = 0;
		first_fr = 1;
		w_reg = WIDTH_RST;
		h_reg = HEIGHT_RST;
		key_th = KEY_TH_RST;
		ref_th = REF_TH_RST;
		diff_sum = '0;
		prev_px = WHITE;
		row = 0;
		col = 0;
		pend_kind = PEND_NONE;
		pend_cnt = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed table
		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				wait_idle();
				write_reg(dir_tab[i].idx, dir_tab[i].val);
			end else begin
				send_byte(dir_tab[i].b);
				if (dir_tab[i].typed && (pixel_q.size() == 0
						|| pixel_q[pixel_q.size() - 1].pix !== dir_tab[i].pix
						|| pixel_q[pixel_q.size() - 1].err !== dir_tab[i].err))
					report_bad("directed row", i, dir_tab[i].pix);
			end
		end

		// Random phases, each under its own frame size and thresholds
		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			write_reg(REG_WIDTH, w_tab[ph]);
			write_reg(REG_HEIGHT, h_tab[ph]);
			write_reg(REG_KEY_TH, (ph == 1) ? '0 : (ph == 2) ? TH_MAX : pick_threshold());
			write_reg(REG_REF_TH, (ph == 1) ? TH_MAX : (ph == 2) ? '0 : pick_threshold());
			repeat (30) begin
				kind = $urandom_range(0, 99);
				if (kind < 15) begin
					send_byte(safe_header(BYTE_RAW));
					repeat (3) send_byte($urandom_range(0, 255));
				end else if (kind < 30) begin
					send_byte(safe_header({OP_LUMA, 5'($urandom_range(0, 31))}));
					send_byte($urandom_range(0, 255));
				end else if (kind < 42) begin
					send_byte(safe_header({OP_DELTA, 5'($urandom_range(0, 31))}));
				end else if (kind < 57) begin
					send_byte(safe_header({OP_RUN, pick_count()}));
				end else if (kind < 70) begin
					send_byte(safe_header({OP_COPY, pick_count()}));
				end else if (kind < 82) begin
					b = {2'b10, 6'($urandom_range(0, 63))};
					send_byte(safe_header(b));
				end else if (kind < 94) begin
					b = {2'b11, 6'($urandom_range(0, 63))};
					send_byte(safe_header(b));
				end else begin
					send_byte(safe_header($urandom_range(0, 255)));
				end
			end
		end

		// Drain and finish
		in_valid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		$display("sent %0d code bytes over 8 frame sizes, checked %0d pixels", items, pixels);
		$display("%0d frames closed, %0d mismatches", frames, err_cnt);
		if (err_cnt == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
